FILE: rtl/cab_pkg.sv
// Shared types and sizing constants for the CSR adjacency builder.
// Used by the top level csr_adjacency_builder and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package cab_pkg;

  localparam int unsigned MaxSources = 1024;
  localparam int unsigned MaxValues  = 4096;

  localparam int unsigned SrcW     = $clog2(MaxSources);
  localparam int unsigned OffAddrW = SrcW + 1;
  localparam int unsigned ValAddrW = $clog2(MaxValues);
  localparam int unsigned CntW     = ValAddrW + 1;
  localparam int unsigned NumW     = 11;
  localparam int unsigned DestW    = 16;
  localparam int unsigned SlotW    = 8;

  typedef enum logic [1:0] {
    CMD_COUNT    = 2'd0,
    CMD_FINALIZE = 2'd1,
    CMD_SET      = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_INDEX   = 2'd1,
    STAT_OVERFLOW    = 2'd2,
    STAT_WRONG_PHASE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_WALK
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [SrcW-1:0]  src_index;
    logic [DestW-1:0] dest_value;
    logic [SlotW-1:0] slot;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [DestW-1:0] value_out;
    logic [CntW-1:0]  offset_out;
    logic [CntW-1:0]  degree_out;
    logic [CntW-1:0]  total_out;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/cab_ram.sv
// Generic synchronous RAM, one write port and one registered read port.
// Holds the fill counts and the adjacency values; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module cab_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/cab_ram_2r.sv
// Generic synchronous RAM, one write port and two registered read ports.
// Holds the degree/offset table; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module cab_ram_2r #(
  parameter int unsigned Width = 13,
  parameter int unsigned Depth = 1025,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

FILE: rtl/csr_adjacency_builder.sv
// Top level of the CSR adjacency builder: request FSM, finalize walk, result register.
// Depends on cab_pkg, cab_ram and cab_ram_2r.
`timescale 1ns / 1ps
`default_nettype none

// Builds a compressed sparse row table in three phases: count, finalize, fill.
// After reset a clearing pass zeroes the offset and fill-count memories;
// requests stall during it, register writes are taken. One request is
// in flight at a time. Count and set do a memory read, then an update and
// write back; read does an offset lookup, then a value fetch; and finalize
// walks the sources in use (num_sources counts as at most 1024), one offset
// per cycle through the single write port of the offset memory. Errors are
// answered from the lookup step. A result waits in the output register while
// the next request is accepted.
module csr_adjacency_builder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire cab_pkg::req_t             in_req_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output cab_pkg::rsp_t                  out_rsp_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [cab_pkg::NumW-1:0]  cfg_wdata_i
);

  localparam int unsigned SrcW     = cab_pkg::SrcW;
  localparam int unsigned OffAddrW = cab_pkg::OffAddrW;
  localparam int unsigned ValAddrW = cab_pkg::ValAddrW;
  localparam int unsigned CntW     = cab_pkg::CntW;
  localparam int unsigned NumW     = cab_pkg::NumW;
  localparam int unsigned DestW    = cab_pkg::DestW;

  localparam logic [NumW-1:0]     NumMax   = NumW'(cab_pkg::MaxSources);
  localparam logic [OffAddrW-1:0] ClrLast  = OffAddrW'(cab_pkg::MaxSources);
  localparam logic [CntW-1:0]     TotalMax = CntW'(cab_pkg::MaxValues);

  cab_pkg::state_e state_q, state_d;
  cab_pkg::req_t   req_q, req_d;
  cab_pkg::rsp_t   out_rsp_q, out_rsp_d, rsp;

  logic                out_valid_q, out_valid_d;
  logic [NumW-1:0]     num_src_q, num_src_d;
  logic                fin_q, fin_d;
  logic [CntW-1:0]     run_total_q, run_total_d;
  logic [OffAddrW-1:0] latched_n_q, latched_n_d;
  logic [OffAddrW-1:0] walk_idx_q, walk_idx_d;
  logic                wr_pend_q, wr_pend_d;
  logic [SrcW-1:0]     wr_idx_q, wr_idx_d;
  logic [OffAddrW-1:0] clr_q, clr_d;

  logic                off_we;
  logic [OffAddrW-1:0] off_waddr;
  logic [CntW-1:0]     off_wdata;
  logic [OffAddrW-1:0] off_raddr_a, off_raddr_b;
  logic [CntW-1:0]     off_rdata_a, off_rdata_b;

  logic                fill_we;
  logic [SrcW-1:0]     fill_waddr;
  logic [CntW-1:0]     fill_wdata;
  logic [SrcW-1:0]     fill_raddr;
  logic [CntW-1:0]     fill_rdata;

  logic                val_we;
  logic [ValAddrW-1:0] val_waddr;
  logic [DestW-1:0]    val_wdata;
  logic [ValAddrW-1:0] val_raddr;
  logic [DestW-1:0]    val_rdata;

  logic [SrcW-1:0]     idx_sel;
  logic [NumW-1:0]     active_n;
  logic [CntW-1:0]     base, cap, fill, total_now;
  logic                bad_cnt_idx, bad_fill_idx, out_free, emit;

  cab_ram_2r #(
    .Width (CntW),
    .Depth (cab_pkg::MaxSources + 1)
  ) u_offset_ram (
    .clk_i     (clk_i),
    .we_i      (off_we),
    .waddr_i   (off_waddr),
    .wdata_i   (off_wdata),
    .raddr_a_i (off_raddr_a),
    .raddr_b_i (off_raddr_b),
    .rdata_a_o (off_rdata_a),
    .rdata_b_o (off_rdata_b)
  );

  cab_ram #(
    .Width (CntW),
    .Depth (cab_pkg::MaxSources)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  cab_ram #(
    .Width (DestW),
    .Depth (cab_pkg::MaxValues)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  assign idx_sel     = (state_q == cab_pkg::ST_IDLE) ? in_req_i.src_index : req_q.src_index;
  assign off_raddr_a = (state_q == cab_pkg::ST_WALK) ? walk_idx_q : {1'b0, idx_sel};
  assign off_raddr_b = {1'b0, idx_sel} + OffAddrW'(1);
  assign fill_raddr  = idx_sel;

  assign base      = off_rdata_a;
  assign cap       = off_rdata_b - off_rdata_a;
  assign fill      = fill_rdata;
  assign val_raddr = ValAddrW'(base + CntW'(req_q.slot));
  assign total_now = fin_q ? run_total_q : '0;

  assign active_n     = (num_src_q > NumMax) ? NumMax : num_src_q;
  assign bad_cnt_idx  = (NumW'(req_q.src_index) >= active_n);
  assign bad_fill_idx = (OffAddrW'(req_q.src_index) >= latched_n_q);
  assign out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    fin_d       = fin_q;
    run_total_d = run_total_q;
    latched_n_d = latched_n_q;
    walk_idx_d  = walk_idx_q;
    wr_pend_d   = wr_pend_q;
    wr_idx_d    = wr_idx_q;
    clr_d       = clr_q;
    num_src_d   = cfg_we_i ? cfg_wdata_i : num_src_q;

    off_we     = 1'b0;
    off_waddr  = {1'b0, req_q.src_index};
    off_wdata  = '0;
    fill_we    = 1'b0;
    fill_waddr = req_q.src_index;
    fill_wdata = fill + CntW'(1);
    val_we     = 1'b0;
    val_waddr  = ValAddrW'(base + fill);
    val_wdata  = req_q.dest_value;

    emit      = 1'b0;
    rsp       = '0;
    rsp.total_out = total_now;

    unique case (state_q)
      cab_pkg::ST_CLEAR: begin
        off_we     = 1'b1;
        off_waddr  = clr_q;
        fill_we    = !clr_q[SrcW];
        fill_waddr = clr_q[SrcW-1:0];
        fill_wdata = '0;
        clr_d      = clr_q + OffAddrW'(1);
        if (clr_q == ClrLast) begin
          state_d = cab_pkg::ST_IDLE;
        end
      end
      cab_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = cab_pkg::ST_LOOKUP;
        end
      end
      cab_pkg::ST_LOOKUP: begin
        case (req_q.cmd)
          cab_pkg::CMD_COUNT: begin
            emit = 1'b1;
            if (fin_q) begin
              rsp.status = cab_pkg::STAT_WRONG_PHASE;
            end else if (bad_cnt_idx) begin
              rsp.status = cab_pkg::STAT_BAD_INDEX;
            end else if (run_total_q >= TotalMax) begin
              rsp.status = cab_pkg::STAT_OVERFLOW;
            end else begin
              rsp.offset_out = base + CntW'(1);
              rsp.degree_out = fill;
              off_wdata      = base + CntW'(1);
              if (out_free) begin
                off_we      = 1'b1;
                run_total_d = run_total_q + CntW'(1);
              end
            end
          end
          cab_pkg::CMD_FINALIZE: begin
            if (fin_q) begin
              emit       = 1'b1;
              rsp.status = cab_pkg::STAT_WRONG_PHASE;
            end else begin
              walk_idx_d  = '0;
              wr_pend_d   = 1'b0;
              run_total_d = '0;
              latched_n_d = OffAddrW'(active_n);
              state_d     = cab_pkg::ST_WALK;
            end
          end
          cab_pkg::CMD_SET: begin
            emit = 1'b1;
            if (!fin_q) begin
              rsp.status = cab_pkg::STAT_WRONG_PHASE;
            end else if (bad_fill_idx) begin
              rsp.status = cab_pkg::STAT_BAD_INDEX;
            end else if (fill >= cap) begin
              rsp.status = cab_pkg::STAT_OVERFLOW;
            end else begin
              rsp.offset_out = base;
              rsp.degree_out = fill + CntW'(1);
              val_we         = out_free;
              fill_we        = out_free;
            end
          end
          cab_pkg::CMD_READ: begin
            if (!fin_q) begin
              emit       = 1'b1;
              rsp.status = cab_pkg::STAT_WRONG_PHASE;
            end else if (bad_fill_idx || (CntW'(req_q.slot) >= fill)) begin
              emit       = 1'b1;
              rsp.status = cab_pkg::STAT_BAD_INDEX;
            end else begin
              state_d = cab_pkg::ST_FETCH;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
        if (emit && out_free) begin
          state_d = cab_pkg::ST_IDLE;
        end
      end
      cab_pkg::ST_FETCH: begin
        emit           = 1'b1;
        rsp.value_out  = val_rdata;
        rsp.offset_out = base;
        rsp.degree_out = fill;
        if (out_free) begin
          state_d = cab_pkg::ST_IDLE;
        end
      end
      cab_pkg::ST_WALK: begin
        if (wr_pend_q) begin
          off_we      = 1'b1;
          off_waddr   = {1'b0, wr_idx_q};
          off_wdata   = run_total_q;
          run_total_d = run_total_q + off_rdata_a;
        end
        if (walk_idx_q < latched_n_q) begin
          wr_pend_d  = 1'b1;
          wr_idx_d   = walk_idx_q[SrcW-1:0];
          walk_idx_d = walk_idx_q + OffAddrW'(1);
        end else begin
          wr_pend_d = 1'b0;
        end
        if ((walk_idx_q == latched_n_q) && !wr_pend_q) begin
          off_we        = 1'b1;
          off_waddr     = latched_n_q;
          off_wdata     = run_total_q;
          emit          = 1'b1;
          rsp.total_out = run_total_q;
          if (out_free) begin
            fin_d   = 1'b1;
            state_d = cab_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = cab_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (emit && out_free) begin
      out_valid_d = 1'b1;
      out_rsp_d   = rsp;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cab_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      num_src_q   <= NumMax;
      fin_q       <= 1'b0;
      run_total_q <= '0;
      latched_n_q <= '0;
      walk_idx_q  <= '0;
      wr_pend_q   <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      num_src_q   <= num_src_d;
      fin_q       <= fin_d;
      run_total_q <= run_total_d;
      latched_n_q <= latched_n_d;
      walk_idx_q  <= walk_idx_d;
      wr_pend_q   <= wr_pend_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    out_rsp_q <= out_rsp_d;
    wr_idx_q  <= wr_idx_d;
  end

  assign in_stall_o  = (state_q != cab_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("fill phase left without reset");

  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cab_pkg::ST_CLEAR) |-> !out_valid_o)
    else $error("result issued during clearing pass");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_total_q <= TotalMax)
    else $error("running total exceeds store size");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != cab_pkg::STAT_OK)) |->
      ((out_rsp_o.value_out == '0) && (out_rsp_o.offset_out == '0) &&
       (out_rsp_o.degree_out == '0)))
    else $error("error result carries nonzero payload");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for csr_adjacency_builder: count, finalize and fill phases.
// Predicts every result in-line and compares it field by field; depends on cab_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxSources = cab_pkg::MaxSources;
  localparam int unsigned MaxValues  = cab_pkg::MaxValues;
  localparam int unsigned NumW       = cab_pkg::NumW;
  localparam int unsigned SrcW       = cab_pkg::SrcW;
  localparam int unsigned DestW      = cab_pkg::DestW;
  localparam int unsigned SlotW      = cab_pkg::SlotW;
  localparam int unsigned CntW       = cab_pkg::CntW;

  localparam int unsigned HotSrc    = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ExpDepth  = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  cab_pkg::req_t in_req = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [NumW-1:0] cfg_wdata = '0;
  logic in_stall;
  logic out_valid;
  cab_pkg::rsp_t out_rsp;

  // Predictor state.
  int unsigned start_tab [0:MaxSources];
  int unsigned fill_tab [0:MaxSources-1];
  logic [DestW-1:0] adj_mem [0:MaxValues-1];
  bit filling = 1'b0;
  int unsigned entry_total = 0;
  int unsigned frozen_sources = 0;
  int unsigned num_src = 1024;

  cab_pkg::rsp_t exp_q [0:ExpDepth-1];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  cab_pkg::rsp_t want;
  bit quiet = 1'b0;
  int errors = 0;
  int cycles = 0;

  csr_adjacency_builder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 25);
  end

  function automatic cab_pkg::rsp_t csr_predict(cab_pkg::req_t r);
    cab_pkg::rsp_t o;
    int unsigned n, run, d, base, cap, fill, pos, i, idx;
    o = '0;
    idx = r.src_index;
    n = (num_src > MaxSources) ? MaxSources : num_src;
    case (r.cmd)
      cab_pkg::CMD_COUNT: begin
        if (filling) o.status = cab_pkg::STAT_WRONG_PHASE;
        else if (idx >= n) o.status = cab_pkg::STAT_BAD_INDEX;
        else if (entry_total >= MaxValues) o.status = cab_pkg::STAT_OVERFLOW;
        else begin
          start_tab[idx] = start_tab[idx] + 1;
          entry_total = entry_total + 1;
          o.offset_out = CntW'(start_tab[idx]);
          o.degree_out = CntW'(fill_tab[idx]);
        end
      end
      cab_pkg::CMD_FINALIZE: begin
        if (filling) o.status = cab_pkg::STAT_WRONG_PHASE;
        else begin
          run = 0;
          for (i = 0; i < n; i++) begin
            d = start_tab[i];
            start_tab[i] = run;
            run = run + d;
          end
          start_tab[n] = run;
          entry_total = run;
          frozen_sources = n;
          filling = 1'b1;
        end
      end
      default: begin
        if (!filling) o.status = cab_pkg::STAT_WRONG_PHASE;
        else if (idx >= frozen_sources) o.status = cab_pkg::STAT_BAD_INDEX;
        else begin
          base = start_tab[idx];
          cap = start_tab[idx + 1] - base;
          fill = fill_tab[idx];
          if (r.cmd == cab_pkg::CMD_SET) begin
            if (fill >= cap) o.status = cab_pkg::STAT_OVERFLOW;
            else begin
              pos = base + fill;
              if (pos < MaxValues) adj_mem[pos] = r.dest_value;
              fill_tab[idx] = fill + 1;
              o.offset_out = CntW'(base);
              o.degree_out = CntW'(fill + 1);
            end
          end else begin
            if (r.slot >= fill) o.status = cab_pkg::STAT_BAD_INDEX;
            else begin
              pos = base + r.slot;
              o.value_out = (pos < MaxValues) ? adj_mem[pos] : '0;
              o.offset_out = CntW'(base);
              o.degree_out = CntW'(fill);
            end
          end
        end
      end
    endcase
    o.total_out = filling ? CntW'(entry_total) : '0;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = exp_q[exp_rd % ExpDepth];
        exp_rd++;
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          errors++;
        end
        if (out_rsp.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_rsp.value_out);
          errors++;
        end
        if (out_rsp.offset_out !== want.offset_out) begin
          $error("offset_out: expected %0d, got %0d", want.offset_out, out_rsp.offset_out);
          errors++;
        end
        if (out_rsp.degree_out !== want.degree_out) begin
          $error("degree_out: expected %0d, got %0d", want.degree_out, out_rsp.degree_out);
          errors++;
        end
        if (out_rsp.total_out !== want.total_out) begin
          $error("total_out: expected %0d, got %0d", want.total_out, out_rsp.total_out);
          errors++;
        end
      end
    end
  end

  function automatic cab_pkg::req_t mk_req(int unsigned c, int unsigned idx,
                                           int unsigned dest, int unsigned slot);
    cab_pkg::req_t r;
    r.cmd = cab_pkg::cmd_e'(c[1:0]);
    r.src_index = SrcW'(idx);
    r.dest_value = DestW'(dest);
    r.slot = SlotW'(slot);
    return r;
  endfunction

  task automatic send_req(input cab_pkg::req_t r);
    cab_pkg::rsp_t pred;
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pred = csr_predict(r);
    exp_q[exp_wr % ExpDepth] = pred;
    exp_wr++;
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_num_sources(input int unsigned v);
    wait_drained();
    cfg_wdata <= NumW'(v);
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    num_src = v;
  endtask

  task automatic test_count_basics();
    write_num_sources(1);
    send_req(mk_req(cab_pkg::CMD_COUNT, 0, 0, 0));
    send_req(mk_req(cab_pkg::CMD_COUNT, 1, 0, 0));
    send_req(mk_req(cab_pkg::CMD_COUNT, 1023, 16'hFFFF, 255));
    send_req(mk_req(cab_pkg::CMD_SET, 0, 16'hFFFF, 0));
    send_req(mk_req(cab_pkg::CMD_READ, 0, 0, 255));
    write_num_sources(0);
    send_req(mk_req(cab_pkg::CMD_COUNT, 0, 0, 0));
    write_num_sources(2047);
    send_req(mk_req(cab_pkg::CMD_COUNT, 1023, 0, 0));
    write_num_sources(1024);
  endtask

  task automatic test_random_counts();
    int unsigned k, r;
    for (k = 0; k < 250; k++) begin
      if (k == 125) write_num_sources(512);
      r = $urandom_range(99);
      if (r < 70) send_req(mk_req(cab_pkg::CMD_COUNT, $urandom_range(HotSrc - 1), 0, 0));
      else if (r < 82)
        send_req(mk_req(cab_pkg::CMD_COUNT, $urandom_range(1023), $urandom_range(65535), 0));
      else if (r < 94)
        send_req(mk_req(cab_pkg::CMD_SET, $urandom_range(1023), $urandom_range(65535),
                        $urandom_range(255)));
      else
        send_req(mk_req(cab_pkg::CMD_READ, $urandom_range(1023), $urandom_range(65535),
                        $urandom_range(255)));
    end
    write_num_sources(1024);
  endtask

  task automatic test_finalize();
    write_num_sources(700);
    send_req(mk_req(cab_pkg::CMD_FINALIZE, 0, 0, 0));
    send_req(mk_req(cab_pkg::CMD_FINALIZE, 1023, 16'hFFFF, 255));
    send_req(mk_req(cab_pkg::CMD_COUNT, 0, 0, 0));
    write_num_sources(1);
    send_req(mk_req(cab_pkg::CMD_SET, 699, 16'h0000, 0));
    send_req(mk_req(cab_pkg::CMD_SET, 700, 16'h1234, 0));
    send_req(mk_req(cab_pkg::CMD_SET, 1023, 16'hFFFF, 0));
    send_req(mk_req(cab_pkg::CMD_READ, 1, 0, 255));
    send_req(mk_req(cab_pkg::CMD_SET, 0, 16'hFFFF, 0));
    send_req(mk_req(cab_pkg::CMD_READ, 0, 0, 0));
    write_num_sources(0);
    send_req(mk_req(cab_pkg::CMD_READ, 699, 0, 0));
  endtask

  task automatic test_random_fill();
    int unsigned k, r, idx;
    for (k = 0; k < 600; k++) begin
      if (k == 300) write_num_sources(2047);
      quiet = (k >= 150) && (k < 290);
      r = $urandom_range(99);
      idx = $urandom_range(HotSrc - 1);
      if (r < 50)
        send_req(mk_req(cab_pkg::CMD_SET, idx, $urandom_range(65535), $urandom_range(255)));
      else if (r < 75)
        send_req(mk_req(cab_pkg::CMD_READ, idx, $urandom_range(65535),
                        fill_tab[idx] > 0 ? $urandom_range(fill_tab[idx] - 1)
                                          : $urandom_range(255)));
      else if (r < 82)
        send_req(mk_req(cab_pkg::CMD_SET, $urandom_range(1023), $urandom_range(65535),
                        $urandom_range(255)));
      else if (r < 89)
        send_req(mk_req(cab_pkg::CMD_READ, $urandom_range(1023), $urandom_range(65535),
                        $urandom_range(255)));
      else if (r < 95)
        send_req(mk_req($urandom_range(1), $urandom_range(1023), $urandom_range(65535),
                        $urandom_range(255)));
      else
        send_req(mk_req(cab_pkg::CMD_READ, idx, 0, $urandom_range(255)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i <= MaxSources; i++) start_tab[i] = 0;
    for (int i = 0; i < MaxSources; i++) fill_tab[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_count_basics();
    test_random_counts();
    test_finalize();
    test_random_fill();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
